### src/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lkv_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_SET = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} entry_t;

endpackage

`default_nettype wire

### src/lkv_cell.sv
// One storage cell of the recency-ordered ring of cache entries.
`default_nettype none

module lkv_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift_en,
	input  wire lkv_pkg::entry_t din,
	output lkv_pkg::entry_t      dout
);

	logic                       valid_q;
	logic [lkv_pkg::DATA_W-1:0] key_q;
	logic [lkv_pkg::DATA_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q   <= din.key;
			value_q <= din.value;
		end
	end

	assign dout = '{valid: valid_q, key: key_q, value: value_q};

endmodule

`default_nettype wire

### src/lkv_ctrl.sv
// Sequencer at the head of the ring: search pass, then rebuild pass with move to front.
`default_nettype none

module lkv_ctrl #(
	parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              req_type,
	input  wire logic signed [lkv_pkg::DATA_W-1:0] key,
	input  wire logic signed [lkv_pkg::DATA_W-1:0] write_value,
	input  wire logic signed [lkv_pkg::DATA_W-1:0] fill_value,
	input  wire logic [lkv_pkg::CAP_W-1:0]         capacity,
	input  wire lkv_pkg::entry_t                   head,
	output lkv_pkg::entry_t                        tail,
	output logic                                   shift_en,
	output logic                                   busy,
	output logic                                   done,
	output logic signed [lkv_pkg::DATA_W-1:0]      read_value,
	output logic                                   hit
);

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
	localparam logic [IW-1:0] LAST_STEP = IW'(MAX_ENTRIES - 1);
	localparam logic [EW-1:0] MAX_CAP = EW'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_SEARCH  = 3'b010,
		ST_REBUILD = 3'b100
	} state_t;

	state_t                     state_q;
	logic [IW-1:0]              step_q;
	logic [CW-1:0]              count_q;
	logic                       hit_q;
	logic                       removed_q;
	logic                       done_q;
	logic                       set_q;
	logic [lkv_pkg::DATA_W-1:0] key_q;
	logic [lkv_pkg::DATA_W-1:0] new_val_q;
	lkv_pkg::entry_t            hold_q;

	logic [EW-1:0]   cap_ext;
	logic [EW-1:0]   eff_cap;
	logic            evict;
	logic [CW-1:0]   rem_idx;
	logic            match;
	logic            at_removal;
	logic            last_step;
	lkv_pkg::entry_t new_entry;

	// Valid entries sit at positions 0 to count-1, most recent first.
	always_comb begin
		cap_ext = EW'(capacity);
		if (cap_ext == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > MAX_CAP) begin
			eff_cap = MAX_CAP;
		end else begin
			eff_cap = cap_ext;
		end
		evict      = (EW'(count_q) >= eff_cap);
		rem_idx    = evict ? (count_q - CW'(1)) : count_q;
		match      = head.valid && (head.key == key_q);
		at_removal = hit_q ? match : (CW'(step_q) == rem_idx);
		last_step  = (step_q == LAST_STEP);
		new_entry  = '{valid: 1'b1, key: key_q, value: new_val_q};
	end

	// Until the removed entry passes, the ring is refilled one position late, which
	// opens position 0 for the new entry.
	always_comb begin
		tail = head;
		if (state_q == ST_REBUILD && !removed_q) begin
			tail = (step_q == '0) ? new_entry : hold_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			count_q   <= '0;
			hit_q     <= 1'b0;
			removed_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SEARCH;
						step_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (match) begin
						hit_q <= 1'b1;
					end
					if (last_step) begin
						state_q   <= ST_REBUILD;
						step_q    <= '0;
						removed_q <= 1'b0;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				ST_REBUILD: begin
					if (!removed_q && at_removal) begin
						removed_q <= 1'b1;
					end
					if (last_step) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						if (!hit_q && !evict) begin
							count_q <= count_q + CW'(1);
						end
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			key_q     <= key;
			set_q     <= (req_type == lkv_pkg::REQ_SET);
			new_val_q <= (req_type == lkv_pkg::REQ_SET) ? write_value : fill_value;
		end
		if (state_q == ST_SEARCH && match && !set_q) begin
			new_val_q <= head.value;
		end
		if (state_q == ST_REBUILD && !removed_q) begin
			hold_q <= head;
		end
	end

	assign shift_en   = (state_q == ST_SEARCH) || (state_q == ST_REBUILD);
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = set_q ? '0 : new_val_q;

endmodule

`default_nettype wire

### src/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache built as a ring of cells.
//
//   channel   | ports                                        | transaction at edge
//   ----------+----------------------------------------------+---------------------
//   request   | start, busy, req_type, key, write_value,     | start && !busy
//             | fill_value                                   |
//   result    | done, read_value, hit                        | done
//   config    | cfg_we, cfg_wdata                            | cfg_we
//
// Busy stays high while an accepted request is in work: the ring of cells
// rotates once past the head to look up the key, then once more to move the entry to the
// front and, on a miss with a full cache, drop the least recent entry. The done strobe
// appears in the cycle after the last rotation step, with busy already low, so the next
// request can be accepted at the end of that same cycle; no new request is taken while busy.
// Reset clears every valid bit directly; no clearing pass is needed.
// The receiver cannot stall; a result is on the ports for exactly one cycle.
`default_nettype none

module lru_key_value_cache #(
	parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              req_type,
	input  wire logic signed [lkv_pkg::DATA_W-1:0] key,
	input  wire logic signed [lkv_pkg::DATA_W-1:0] write_value,
	input  wire logic signed [lkv_pkg::DATA_W-1:0] fill_value,
	input  wire logic                              cfg_we,
	input  wire logic [lkv_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                                   done,
	output logic signed [lkv_pkg::DATA_W-1:0]      read_value,
	output logic                                   hit
);

	logic [lkv_pkg::CAP_W-1:0] cap_q;
	logic                      shift_en;
	lkv_pkg::entry_t           tail;
	lkv_pkg::entry_t           cell_out [MAX_ENTRIES];
	lkv_pkg::entry_t           cell_in  [MAX_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Each cell takes its upper neighbor; the last cell takes what the head sends back.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign cell_in[i] = tail;
		end else begin : g_link
			assign cell_in[i] = cell_out[i+1];
		end

		lkv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.din      (cell_in[i]),
			.dout     (cell_out[i])
		);
	end

	lkv_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.key         (key),
		.write_value (write_value),
		.fill_value  (fill_value),
		.capacity    (cap_q),
		.head        (cell_out[0]),
		.tail        (tail),
		.shift_en    (shift_en),
		.busy        (busy),
		.done        (done),
		.read_value  (read_value),
		.hit         (hit)
	);

endmodule

`default_nettype wire

### src/lkv_checker.sv
// Port-level checks of the cache handshake, bound to the top level.
`default_nettype none

module lkv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// An accepted transaction keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// Every finished request reports its result as busy drops.
	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result not preceded by a busy request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
